>>> rtl/max_pool_2d_stream_unit_defines.svh
// assertion macros shared by the max pooling rtl
// no dependencies; expects i_clk and i_rst_n in the using module
`ifndef MAX_POOL_2D_STREAM_UNIT_DEFINES_SVH
`define MAX_POOL_2D_STREAM_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mps_pkg.sv
// shared constants for the max pooling stream unit
// no dependencies
package mps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    localparam int HEIGHT_LIMIT  = 256;
    localparam int CHANNEL_LIMIT = 1024;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [8:0]            t_dim9;
    typedef logic [3:0]            t_win4;
    typedef logic [10:0]           t_chan11;

endpackage

>>> rtl/mps_in_if.sv
// input stream channel: valid, ready and one sample per beat
// depends on nothing but its width parameter
interface mps_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/mps_out_if.sv
// result stream channel: valid, ready, pooled value and end flags
// depends on nothing but its width parameter
interface mps_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic                          end_of_plane;
    logic                          end_of_map;

    modport source (output valid, output pooled_value, output end_of_plane,
                    output end_of_map, input ready);
    modport sink   (input valid, input pooled_value, input end_of_plane,
                    input end_of_map, output ready);
endinterface

>>> rtl/mps_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/max_pool_2d_stream_unit.sv
// max pooling stream unit: one sample accepted per beat when idle
// a sample that closes no window runs the remainder unit (S_DIV) over VW dividend bits, then S_WR
// VW = max(clog2(MAX_WIDTH)+1, 9); a closing sample then scans k*k entries in S_SCAN and waits in S_HOLD
// a new sample is accepted only once back in idle; S_HOLD waits while a result waits for ready
// reset (synchronous, active low) clears positions, control and loads register defaults
// line store contents are not cleared; only entries written in the current plane are read
module max_pool_2d_stream_unit #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mps_in_if.sink              i_pix,
    mps_out_if.source           o_res,
    input  logic                i_cfg_we,
    input  mps_pkg::t_cfg_idx   i_cfg_idx,
    input  mps_pkg::t_cfg_data  i_cfg_data
);
    import mps_pkg::*;

    `include "max_pool_2d_stream_unit_defines.svh"

    // widths derived from the parameters
    localparam int CW    = $clog2(MAX_WIDTH);                 // column index
    localparam int WW    = CW + 1;                            // clamped width
    localparam int VW    = (CW + 1 > 9) ? CW + 1 : 9;         // dividend width
    localparam int DW    = ($clog2(MAX_WINDOW + 1) > 4) ? $clog2(MAX_WINDOW + 1) : 4;
    localparam int KW    = $clog2(MAX_WINDOW);                // line / window index
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(VW + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    // one restoring remainder step: shift in a bit, subtract if it fits
    function automatic logic [DW-1:0] f_rem_step(input logic [DW-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [DW-1:0] dsr);
        logic [DW:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, dsr}) begin
            f_rem_step = DW'(t - {1'b0, dsr});
        end else begin
            f_rem_step = t[DW-1:0];
        end
    endfunction

    // configuration registers
    t_dim9   r_plane_height;
    t_dim9   r_plane_width;
    t_win4   r_window_size;
    t_win4   r_window_stride;
    t_chan11 r_channel_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_height  <= 9'd28;
            r_plane_width   <= 9'd28;
            r_window_size   <= 4'd2;
            r_window_stride <= 4'd2;
            r_channel_count <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLANE_HEIGHT:  r_plane_height  <= i_cfg_data[8:0];
                CFG_PLANE_WIDTH:   r_plane_width   <= i_cfg_data[8:0];
                CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[3:0];
                CFG_WINDOW_STRIDE: r_window_stride <= i_cfg_data[3:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // effective geometry: zero counts as one, oversize is clamped
    logic [8:0]    w_h;
    logic [WW-1:0] w_w;
    logic [10:0]   w_ch;
    logic [3:0]    w_s;

    always_comb begin
        if (r_plane_height == '0) begin
            w_h = 9'd1;
        end else if (32'(r_plane_height) > 32'(HEIGHT_LIMIT)) begin
            w_h = 9'(HEIGHT_LIMIT);
        end else begin
            w_h = r_plane_height;
        end
        if (r_plane_width == '0) begin
            w_w = WW'(1);
        end else if (32'(r_plane_width) > 32'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_plane_width);
        end
        if (r_channel_count == '0) begin
            w_ch = 11'd1;
        end else if (32'(r_channel_count) > 32'(CHANNEL_LIMIT)) begin
            w_ch = 11'(CHANNEL_LIMIT);
        end else begin
            w_ch = r_channel_count;
        end
        w_s = (r_window_stride == '0) ? 4'd1 : r_window_stride;
    end

    // stream positions; the line counter tracks row mod MAX_WINDOW
    logic [7:0]    r_row_pos;
    logic [CW-1:0] r_col_pos;
    logic [9:0]    r_chan_pos;
    logic [KW-1:0] r_line_pos;

    // positions after restart at a shrunk limit
    logic [7:0]    w_r;
    logic [CW-1:0] w_c;
    logic [9:0]    w_chp;
    logic [KW-1:0] w_ln;
    logic          w_accept;

    assign w_r   = ({1'b0, r_row_pos} >= w_h) ? '0 : r_row_pos;
    assign w_ln  = ({1'b0, r_row_pos} >= w_h) ? '0 : r_line_pos;
    assign w_c   = ({1'b0, r_col_pos} >= w_w) ? '0 : r_col_pos;
    assign w_chp = ({1'b0, r_chan_pos} >= w_ch) ? '0 : r_chan_pos;

    // per-sample context captured at accept
    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [CW-1:0]             r_c;
    logic [KW-1:0]             r_kline;
    logic [KW-1:0]             r_km1;
    logic                      r_win_ok;
    logic                      r_eop;
    logic                      r_eom;
    logic [DW-1:0]             r_s;

    // remainder unit: (r+1-k) mod s and (c+1-k) mod s
    logic [VW-1:0] r_dvd_row, r_dvd_col;
    logic [DW-1:0] r_rem_row, r_rem_col;
    logic [BW-1:0] r_bit;

    // line store scan
    logic [KW-1:0] r_dy, r_dx;
    logic [KW-1:0] r_line;
    logic [CW-1:0] r_col;
    logic          r_issue_done;
    logic          r_pend;
    logic          r_first;
    logic signed [SAMPLE_BITS-1:0] r_best;

    // output register
    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_value;
    logic                          r_o_eop;
    logic                          r_o_eom;

    logic [AW-1:0]          w_waddr, w_raddr;
    logic                   w_we, w_re;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic                   w_closes;
    logic                   w_out_free;

    assign w_accept   = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || o_res.ready;

    // window closes when it fits and both phase remainders are zero
    assign w_closes = r_win_ok && (r_rem_row == '0) && (r_rem_col == '0);

    // line-major addressing into the line store
    assign w_we    = (r_state == S_WR);
    assign w_waddr = AW'(AW'(r_kline) * AW'(MAX_WIDTH) + AW'(r_c));
    assign w_re    = (r_state == S_SCAN) && !r_issue_done;
    assign w_raddr = AW'(AW'(r_line) * AW'(MAX_WIDTH) + AW'(r_col));

    mps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == BW'(VW - 1)) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_state = w_closes ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (r_issue_done && !r_pend) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_chan_pos <= '0;
            r_line_pos <= '0;
        end else begin
            r_state <= n_state;
            // positions advance on every accepted beat
            if (w_accept) begin
                if ({1'b0, w_c} + WW'(1) >= w_w) begin
                    r_col_pos <= '0;
                    if ({1'b0, w_r} + 9'd1 >= w_h) begin
                        r_row_pos  <= '0;
                        r_line_pos <= '0;
                        if ({1'b0, w_chp} + 11'd1 >= w_ch) begin
                            r_chan_pos <= '0;
                        end else begin
                            r_chan_pos <= w_chp + 10'd1;
                        end
                    end else begin
                        r_row_pos  <= w_r + 8'd1;
                        r_line_pos <= (w_ln == KW'(MAX_WINDOW - 1)) ? '0 : w_ln + KW'(1);
                    end
                end else begin
                    r_col_pos <= w_c + CW'(1);
                end
            end
        end
    end

    // capture context and run the remainder unit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_pix.sample;
            r_c      <= w_c;
            r_kline  <= w_ln;
            r_km1    <= KW'(r_window_size - 4'd1);
            r_s      <= DW'(w_s);
            r_win_ok <= (r_window_size != '0)
                     && (32'(r_window_size) <= 32'(MAX_WINDOW))
                     && ({5'd0, r_window_size} <= w_h)
                     && (32'(r_window_size) <= 32'(w_w))
                     && ({1'b0, w_r} + 9'd1 >= {5'd0, r_window_size})
                     && (32'(w_c) + 32'd1 >= 32'(r_window_size));
            // last window of the extent: no further origin fits
            r_eop    <= ({1'b0, w_r} + {5'd0, w_s} >= w_h)
                     && (32'(w_c) + 32'(w_s) >= 32'(w_w));
            r_eom    <= ({1'b0, w_chp} + 11'd1 == w_ch);
            r_dvd_row  <= VW'({1'b0, w_r} + 9'd1 - {5'd0, r_window_size});
            r_dvd_col  <= VW'(VW'(w_c) + VW'(1) - VW'(r_window_size));
            r_rem_row  <= '0;
            r_rem_col  <= '0;
            r_bit      <= '0;
        end else if (r_state == S_DIV) begin
            r_rem_row  <= f_rem_step(r_rem_row, r_dvd_row[VW-1], r_s);
            r_rem_col  <= f_rem_step(r_rem_col, r_dvd_col[VW-1], r_s);
            r_dvd_row  <= r_dvd_row << 1;
            r_dvd_col  <= r_dvd_col << 1;
            r_bit      <= r_bit + BW'(1);
        end
    end

    // scan k*k entries, newest line first; read data is registered and returns the cycle after issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_issue_done <= 1'b1;
        end else if (r_state == S_WR) begin
            r_dy         <= '0;
            r_dx         <= '0;
            r_line       <= r_kline;
            r_col        <= r_c;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_first      <= 1'b1;
        end else if (r_state == S_SCAN) begin
            r_pend <= w_re;
            if (w_re) begin
                if (r_dx == r_km1) begin
                    r_dx  <= '0;
                    r_col <= r_c;
                    r_dy  <= r_dy + KW'(1);
                    r_line <= (r_line == '0) ? KW'(MAX_WINDOW - 1) : r_line - KW'(1);
                    if (r_dy == r_km1) begin
                        r_issue_done <= 1'b1;
                    end
                end else begin
                    r_dx  <= r_dx + KW'(1);
                    r_col <= r_col - CW'(1);
                end
            end
            if (r_pend) begin
                if (r_first || ($signed(w_rdata) > r_best)) begin
                    r_best <= $signed(w_rdata);
                end
                r_first <= 1'b0;
            end
        end
    end

    // output register: a finished result waits here while new beats come in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_HOLD && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_HOLD && w_out_free) begin
            r_o_value <= r_best;
            r_o_eop   <= r_eop;
            r_o_eom   <= r_eop && r_eom;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.pooled_value = r_o_value;
    assign o_res.end_of_plane = r_o_eop;
    assign o_res.end_of_map   = r_o_eom;

    `MPS_ASSERT_NEXT(a_accept_starts_div, w_accept, r_state == S_DIV, "accept did not start remainder")
    `MPS_ASSERT_NEXT(a_hold_loads_out, (r_state == S_HOLD) && w_out_free, r_o_valid && (r_state == S_IDLE), "result not loaded")
    `MPS_ASSERT_NOW(a_map_implies_plane, r_o_valid && r_o_eom, r_o_eop, "end of map without end of plane")
    `MPS_ASSERT_NOW(a_scan_in_window, (r_state == S_SCAN) && !r_issue_done, (r_dy <= r_km1) && (r_dx <= r_km1), "scan left the window")
endmodule

>>> tb/max_pool_2d_stream_unit_tb.sv
// testbench for the max pooling stream unit: directed and random sample streams
// depends on mps_pkg, mps_in_if, mps_out_if and max_pool_2d_stream_unit
class pool_scoreboard;
    // per-window expectation: value and end flags
    typedef struct packed {
        logic signed [15:0] value;
        logic               eop;
        logic               eom;
    } t_pooled;

    int unsigned height, width, ksize, stride, chans;
    int unsigned row_pos, col_pos, chan_pos;
    logic signed [15:0] lines [0:2047];
    t_pooled pending [$];
    int errors;

    function new();
        height = 28; width = 28; ksize = 2; stride = 2; chans = 1;
        row_pos = 0; col_pos = 0; chan_pos = 0; errors = 0;
    endfunction

    function void set_reg(mps_pkg::t_cfg_idx idx, int unsigned v);
        case (idx)
            mps_pkg::CFG_PLANE_HEIGHT:  height = v & 9'h1ff;
            mps_pkg::CFG_PLANE_WIDTH:   width  = v & 9'h1ff;
            mps_pkg::CFG_WINDOW_SIZE:   ksize  = v & 4'hf;
            mps_pkg::CFG_WINDOW_STRIDE: stride = v & 4'hf;
            mps_pkg::CFG_CHANNEL_COUNT: chans  = v & 11'h7ff;
            default: ;
        endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function bit closes(int unsigned p, int unsigned k, int unsigned s);
        return (p + 1 >= k) && ((p + 1 - k) % s == 0);
    endfunction

    // note an accepted sample, queue the window max it closes
    function void note_sample(logic signed [15:0] smp);
        int unsigned h, w, ch, s, r, c;
        logic signed [15:0] best, v;
        t_pooled e;
        h = clip(height, 256); w = clip(width, 256); ch = clip(chans, 1024);
        s = (stride == 0) ? 1 : stride;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        if (chan_pos >= ch) chan_pos = 0;
        r = row_pos; c = col_pos;
        lines[(r % 8) * 256 + c] = smp;
        if (ksize >= 1 && ksize <= 8 && ksize <= h && ksize <= w
                && closes(r, ksize, s) && closes(c, ksize, s)) begin
            best = lines[(r % 8) * 256 + c];
            for (int dy = 0; dy < ksize; dy++)
                for (int dx = 0; dx < ksize; dx++) begin
                    v = lines[((r - dy) % 8) * 256 + (c - dx)];
                    if (v > best) best = v;
                end
            e.value = best;
            e.eop = (r == ((h - ksize) / s) * s + ksize - 1)
                 && (c == ((w - ksize) / s) * s + ksize - 1);
            e.eom = e.eop && (chan_pos + 1 == ch);
            pending.push_back(e);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) begin
                row_pos = 0;
                chan_pos++;
                if (chan_pos >= ch) chan_pos = 0;
            end
        end
    endfunction

    function void check_result(logic signed [15:0] val, logic eop, logic eom);
        t_pooled e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %0d eop %0b eom %0b", val, eop, eom);
            return;
        end
        e = pending.pop_front();
        if (e.value !== val || e.eop !== eop || e.eom !== eom) begin
            errors++;
            if (errors <= 10)
                $display("result mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                         e.value, e.eop, e.eom, val, eop, eom);
        end
    endfunction
endclass

module max_pool_2d_stream_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mps_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_idx = '0;
    t_cfg_data i_cfg_data = '0;

    mps_in_if  #(.SAMPLE_BITS(16)) pix_if ();
    mps_out_if #(.SAMPLE_BITS(16)) res_if ();

    max_pool_2d_stream_unit #(
        .MAX_WIDTH(256), .MAX_WINDOW(8), .SAMPLE_BITS(16)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_if.sink), .o_res(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    pool_scoreboard board = new();
    int send_idle_pct = 0;   // chance of a gap before each sample beat
    int recv_idle_pct = 0;   // chance the receiver drops ready in a cycle
    bit hold_off = 1'b0;     // long receiver stall in progress

    initial begin
        pix_if.valid = 1'b0;
        pix_if.sample = '0;
        res_if.ready = 1'b0;
    end

    // receiver: random ready at falling edges, beats checked at rising edges
    always @(negedge i_clk)
        res_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk)
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.pooled_value, res_if.end_of_plane, res_if.end_of_map);

    // register write while idle; the model tracks the same value
    task automatic write_reg(t_cfg_idx idx, int unsigned v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // valid stays up between back-to-back beats, drops only in a gap
    task automatic send_sample(logic signed [15:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.sample <= smp;
        do @(posedge i_clk); while (!pix_if.ready);
        board.note_sample(smp);
        @(negedge i_clk);
    endtask

    // stop offering, wait for outstanding windows, then let the block drain
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic set_geometry(int unsigned h, int unsigned w, int unsigned k,
                                int unsigned s, int unsigned ch);
        settle();
        write_reg(CFG_PLANE_HEIGHT, h);
        write_reg(CFG_PLANE_WIDTH, w);
        write_reg(CFG_WINDOW_SIZE, k);
        write_reg(CFG_WINDOW_STRIDE, s);
        write_reg(CFG_CHANNEL_COUNT, ch);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // full feature maps with random samples
    task automatic send_maps(int n);
        int total;
        total = board.clip(board.height, 256) * board.clip(board.width, 256)
              * board.clip(board.chans, 1024);
        for (int i = 0; i < n * total; i++) send_sample(rand_sample());
    endtask

    int unsigned hh, ww, kk;

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes in a tiny 2x2 window plane, two channels
        set_geometry(2, 2, 2, 2, 2);
        send_sample(16'sh7fff); send_sample(16'sh8000);
        send_sample(16'sh0000); send_sample(16'shffff);
        send_sample(16'sh8000); send_sample(16'sh8000);
        send_sample(16'sh8000); send_sample(16'sh8001);
        // window of one, zero geometry treated as one
        set_geometry(0, 3, 1, 0, 0);
        for (int i = 0; i < 3; i++) send_sample(16'(16'h5555 << i));
        // oversized, zero and larger-than-plane windows: no results
        set_geometry(2, 2, 9, 1, 1);
        send_sample(16'sh1234); send_sample(16'sh4321);
        set_geometry(2, 2, 3, 1, 1);
        send_sample(16'sh0aaa); send_sample(16'sh7555);
        set_geometry(2, 2, 0, 1, 1);
        send_sample(16'sh0001); send_sample(16'sh0002);
        // leftover rows/columns, largest window
        set_geometry(9, 9, 8, 8, 1);
        send_maps(1);
        // oversized registers clamp: one long row
        set_geometry(1, 511, 1, 15, 2047);
        for (int i = 0; i < 20; i++) send_sample(rand_sample());
        set_geometry(1, 256, 2, 1, 1);
        send_maps(1);

        // random phases with the three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
            for (int m = 0; m < 5; m++) begin
                hh = $urandom_range(1, 7); ww = $urandom_range(1, 8);
                kk = $urandom_range(1, (hh < ww) ? hh : ww);
                set_geometry(hh, ww, kk, $urandom_range(1, 4), $urandom_range(1, 3));
                send_maps(1);
            end
        end

        // receiver holds off while samples keep coming
        set_geometry(4, 8, 1, 1, 1);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_maps(1);
                settle();
            end
        join

        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_in_if.sv
rtl/mps_out_if.sv
rtl/mps_ram.sv
rtl/max_pool_2d_stream_unit.sv
tb/max_pool_2d_stream_unit_tb.sv
